// File: rtl/core/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

	// Output fraction width; full scale is 2^OUT_BITS - 1 (supported range 8..24)
	localparam int OUT_BITS = 16;

	// Input clamps
	localparam logic [8:0] HUE_MAX = 9'd359;
	localparam logic [6:0] PCT_MAX = 7'd100;

	// Channel numerators are exact integers over DENOM = 10000 * 60
	localparam int NUM_W = 20;
	localparam int DENOM = 600000;
	localparam int N_W   = NUM_W + OUT_BITS;

	// Request: one HSV color
	typedef struct packed {
		logic [8:0] hue_deg;
		logic [6:0] sat_pct;
		logic [6:0] val_pct;
	} hsv_req_t;

	// Result: one RGB color
	typedef struct packed {
		logic [OUT_BITS-1:0] red_frac;
		logic [OUT_BITS-1:0] green_frac;
		logic [OUT_BITS-1:0] blue_frac;
	} rgb_res_t;

endpackage

// File: rtl/core/hsv_to_rgb_converter.sv
// HSV to RGB color converter. Takes one request per clock cycle: busy is always
// low, and a request is taken at every edge where start is high. Each result
// appears on result for exactly one cycle, marked by done, in request order.
// Results pass through five register stages (clamp, products, channel select,
// scaling, division by reciprocal multiplication). The receiver cannot stall the
// pipeline, so it must take every result in the cycle it is shown. Hue above 359
// and percentages above 100 saturate; outputs are rounded to nearest, halves up.
module hsv_to_rgb_converter (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  hsv2rgb_pkg::hsv_req_t request,
	output logic                  done,
	output hsv2rgb_pkg::rgb_res_t result
);

	import hsv2rgb_pkg::*;

	localparam logic [2:0] SEC_0 = 3'd0;
	localparam logic [2:0] SEC_1 = 3'd1;
	localparam logic [2:0] SEC_2 = 3'd2;
	localparam logic [2:0] SEC_3 = 3'd3;
	localparam logic [2:0] SEC_4 = 3'd4;
	localparam logic [2:0] SEC_5 = 3'd5;

	localparam logic [N_W-1:0] HALF_N = N_W'(DENOM / 2);

	// Stage 1: clamp, sector, triangle weight, small products
	logic [8:0]  h_c;
	logic [6:0]  s_c;
	logic [6:0]  v_c;
	logic [2:0]  sec_c;
	logic [6:0]  r_c;
	logic [5:0]  t_c;

	logic        vld_s1;
	logic [2:0]  sec_s1;
	logic [6:0]  v_s1;
	logic [5:0]  t_s1;
	logic [13:0] sv_s1;
	logic [13:0] vms_s1;

	assign busy = 1'b0;

	always_comb begin
		h_c = (request.hue_deg > HUE_MAX) ? HUE_MAX : request.hue_deg;
		s_c = (request.sat_pct > PCT_MAX) ? PCT_MAX : request.sat_pct;
		v_c = (request.val_pct > PCT_MAX) ? PCT_MAX : request.val_pct;
		// h mod 120 taken from the sector
		if (h_c >= 9'd300) begin
			sec_c = SEC_5;
			r_c   = 7'(h_c - 9'd240);
		end else if (h_c >= 9'd240) begin
			sec_c = SEC_4;
			r_c   = 7'(h_c - 9'd240);
		end else if (h_c >= 9'd180) begin
			sec_c = SEC_3;
			r_c   = 7'(h_c - 9'd120);
		end else if (h_c >= 9'd120) begin
			sec_c = SEC_2;
			r_c   = 7'(h_c - 9'd120);
		end else if (h_c >= 9'd60) begin
			sec_c = SEC_1;
			r_c   = 7'(h_c);
		end else begin
			sec_c = SEC_0;
			r_c   = 7'(h_c);
		end
		// t = 60 - |r - 60|
		t_c = (r_c >= 7'd60) ? 6'(7'd120 - r_c) : 6'(r_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		sec_s1 <= sec_c;
		v_s1   <= v_c;
		t_s1   <= t_c;
		sv_s1  <= 14'(s_c) * 14'(v_c);
		vms_s1 <= 14'(v_c) * 14'(PCT_MAX - s_c);
	end

	// Stage 2: max, min and the chroma-weighted part of mid
	logic                vld_s2;
	logic [2:0]          sec_s2;
	logic [NUM_W-1:0]    hi_s2;
	logic [NUM_W-1:0]    lo_s2;
	logic [NUM_W-1:0]    svt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		sec_s2 <= sec_s1;
		hi_s2  <= NUM_W'(v_s1) * NUM_W'(6000);
		lo_s2  <= NUM_W'(vms_s1) * NUM_W'(60);
		svt_s2 <= NUM_W'(sv_s1) * NUM_W'(t_s1);
	end

	// Stage 3: mid and per-sector channel placement
	logic [NUM_W-1:0] mid_c;
	logic [NUM_W-1:0] ch_c  [3];
	logic             vld_s3;
	logic [NUM_W-1:0] ch_s3 [3];

	always_comb begin
		mid_c = lo_s2 + svt_s2;
		case (sec_s2)
			SEC_0: begin
				ch_c[0] = hi_s2;  ch_c[1] = mid_c; ch_c[2] = lo_s2;
			end
			SEC_1: begin
				ch_c[0] = mid_c;  ch_c[1] = hi_s2; ch_c[2] = lo_s2;
			end
			SEC_2: begin
				ch_c[0] = lo_s2;  ch_c[1] = hi_s2; ch_c[2] = mid_c;
			end
			SEC_3: begin
				ch_c[0] = lo_s2;  ch_c[1] = mid_c; ch_c[2] = hi_s2;
			end
			SEC_4: begin
				ch_c[0] = mid_c;  ch_c[1] = lo_s2; ch_c[2] = hi_s2;
			end
			default: begin
				ch_c[0] = hi_s2;  ch_c[1] = lo_s2; ch_c[2] = mid_c;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			ch_s3[c] <= ch_c[c];
		end
	end

	// Stage 4: num * FS + DENOM/2, with FS = 2^OUT_BITS - 1 as shift and subtract
	logic           vld_s4;
	logic [N_W-1:0] n_s4 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			n_s4[c] <= {ch_s3[c], {OUT_BITS{1'b0}}} - N_W'(ch_s3[c]) + HALF_N;
		end
	end

	// Stage 5: divide by DENOM = 64 * 9375; drop six bits, then multiply by
	// ceil(2^RCP_SH / 9375), exact for every dividend below 2^Q_W
	localparam int DEN_SHIFT = 6;
	localparam int DEN_ODD   = DENOM >> DEN_SHIFT;
	localparam int Q_W       = N_W - DEN_SHIFT;
	localparam int RCP_SH    = Q_W + $clog2(DEN_ODD);
	localparam int RCP_W     = Q_W + 1;
	localparam int P_W       = Q_W + RCP_W;
	localparam logic [RCP_W-1:0] RCP =
		RCP_W'(((64'd1 << RCP_SH) + 64'(DEN_ODD - 1)) / 64'(DEN_ODD));

	logic                vld_s5;
	logic [P_W-1:0]      prod_c [3];
	logic [OUT_BITS-1:0] q_s5   [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			prod_c[c] = P_W'(n_s4[c][N_W-1:DEN_SHIFT]) * P_W'(RCP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			q_s5[c] <= prod_c[c][RCP_SH +: OUT_BITS];
		end
	end

	// Result
	assign done              = vld_s5;
	assign result.red_frac   = q_s5[0];
	assign result.green_frac = q_s5[1];
	assign result.blue_frac  = q_s5[2];

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import hsv2rgb_pkg::*;

	localparam int LATENCY     = 5;
	localparam int STALL_LIMIT = 2000;
	localparam int GAP_PCT     = 31;

	logic     clk     = 1'b0;
	logic     arst_n  = 1'b0;
	logic     start   = 1'b0;
	hsv_req_t request = '0;
	logic     busy;
	logic     done;
	rgb_res_t result;

	// Colors waiting to be sent, expected colors waiting to come out
	hsv_req_t colors_pending[$];
	rgb_res_t rgb_expected[$];
	hsv_req_t hsv_sent[$];

	bit          steady_feed = 1'b0;
	int unsigned n_sent      = 0;
	int unsigned n_checked   = 0;
	int unsigned n_clamped   = 0;
	int unsigned n_directed  = 0;
	int unsigned n_mismatch  = 0;
	int unsigned quiet_cycles = 0;

	hsv_to_rgb_converter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.done   (done),
		.result (result)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Round num/600000 scaled to full scale, halves up
	function automatic logic [63:0] scale_to_frac(logic [63:0] num);
		logic [63:0] full;
		full = (64'd1 << OUT_BITS) - 64'd1;
		return (num * full + 64'(DENOM / 2)) / 64'(DENOM);
	endfunction

	// Expected RGB for one HSV color, exact integer arithmetic over 600000
	function automatic rgb_res_t rgb_from_hsv(hsv_req_t c);
		logic [63:0] h, s, v, rem, ramp, hi_num, lo_num, mid_num, r_num, g_num, b_num;
		rgb_res_t res;
		h = (c.hue_deg > HUE_MAX) ? 64'(HUE_MAX) : 64'(c.hue_deg);
		s = (c.sat_pct > PCT_MAX) ? 64'(PCT_MAX) : 64'(c.sat_pct);
		v = (c.val_pct > PCT_MAX) ? 64'(PCT_MAX) : 64'(c.val_pct);
		rem  = h % 120;
		ramp = (rem >= 60) ? (120 - rem) : rem;
		hi_num  = v * 6000;
		lo_num  = v * (100 - s) * 60;
		mid_num = lo_num + s * v * ramp;
		case (h / 60)
			0: begin
				r_num = hi_num;  g_num = mid_num; b_num = lo_num;
			end
			1: begin
				r_num = mid_num; g_num = hi_num;  b_num = lo_num;
			end
			2: begin
				r_num = lo_num;  g_num = hi_num;  b_num = mid_num;
			end
			3: begin
				r_num = lo_num;  g_num = mid_num; b_num = hi_num;
			end
			4: begin
				r_num = mid_num; g_num = lo_num;  b_num = hi_num;
			end
			default: begin
				r_num = hi_num;  g_num = lo_num;  b_num = mid_num;
			end
		endcase
		res.red_frac   = OUT_BITS'(scale_to_frac(r_num));
		res.green_frac = OUT_BITS'(scale_to_frac(g_num));
		res.blue_frac  = OUT_BITS'(scale_to_frac(b_num));
		return res;
	endfunction

	task automatic queue_color(int unsigned h, int unsigned s, int unsigned v);
		hsv_req_t c;
		c.hue_deg = h[8:0];
		c.sat_pct = s[6:0];
		c.val_pct = v[6:0];
		if (c.hue_deg > HUE_MAX || c.sat_pct > PCT_MAX || c.val_pct > PCT_MAX)
			n_clamped++;
		colors_pending.push_back(c);
	endtask

	// Mostly legal colors, some with out-of-range fields to hit the clamps
	task automatic queue_random(int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 12)
				queue_color($urandom_range(0, 511), $urandom_range(0, 127),
					$urandom_range(0, 127));
			else
				queue_color($urandom_range(0, 359), $urandom_range(0, 100),
					$urandom_range(0, 100));
		end
	endtask

	task automatic drain_pipeline();
		while (colors_pending.size() != 0 || rgb_expected.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	// Driver: new request or idle at each falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (colors_pending.size() != 0 &&
				(steady_feed || $urandom_range(0, 99) >= GAP_PCT)) begin
			start   <= 1'b1;
			request <= colors_pending[0];
		end else begin
			start   <= 1'b0;
			request <= hsv_req_t'($urandom_range(0, (1 << $bits(hsv_req_t)) - 1));
		end
	end

	// Monitor: record accepted requests, check each result against the oldest one
	always @(posedge clk) begin
		rgb_res_t want;
		hsv_req_t src;
		if (arst_n) begin
			if (start && !busy) begin
				rgb_expected.push_back(rgb_from_hsv(request));
				hsv_sent.push_back(request);
				void'(colors_pending.pop_front());
				n_sent++;
			end
			if (done) begin
				if (rgb_expected.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("ERROR: unexpected result r=%0d g=%0d b=%0d",
							result.red_frac, result.green_frac, result.blue_frac);
				end else begin
					want = rgb_expected.pop_front();
					src  = hsv_sent.pop_front();
					n_checked++;
					if (result.red_frac !== want.red_frac ||
							result.green_frac !== want.green_frac ||
							result.blue_frac !== want.blue_frac) begin
						n_mismatch++;
						if (n_mismatch <= 10)
							$display("ERROR: h=%0d s=%0d v=%0d exp %0d/%0d/%0d got %0d/%0d/%0d",
								src.hue_deg, src.sat_pct, src.val_pct,
								want.red_frac, want.green_frac, want.blue_frac,
								result.red_frac, result.green_frac, result.blue_frac);
					end
				end
			end
		end
	end

	// Watchdog on cycles without any request or result moving
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed: sector edges, saturation/value extremes, clamped fields
		queue_color(0, 100, 100);
		queue_color(59, 100, 100);
		queue_color(60, 100, 100);
		queue_color(90, 100, 100);
		queue_color(119, 100, 100);
		queue_color(120, 100, 100);
		queue_color(179, 100, 100);
		queue_color(180, 100, 100);
		queue_color(239, 100, 100);
		queue_color(240, 100, 100);
		queue_color(299, 100, 100);
		queue_color(300, 100, 100);
		queue_color(359, 100, 100);
		queue_color(30, 0, 100);
		queue_color(200, 100, 0);
		queue_color(0, 0, 0);
		queue_color(75, 50, 50);
		queue_color(360, 100, 100);
		queue_color(511, 127, 127);
		queue_color(100, 101, 60);
		queue_color(100, 60, 101);
		queue_color(256, 64, 64);
		queue_color(333, 1, 1);
		queue_color(45, 127, 33);
		n_directed = colors_pending.size();
		drain_pipeline();

		queue_random(600);
		// Hold the sender until the pipeline is empty
		drain_pipeline();

		// Back-to-back requests, then random gaps again
		steady_feed = 1'b1;
		queue_random(400);
		while (colors_pending.size() != 0)
			@(posedge clk);
		steady_feed = 1'b0;
		queue_random(550);
		drain_pipeline();

		$display("Sent %0d colors (%0d directed, %0d with clamped fields), checked %0d results",
			n_sent, n_directed, n_clamped, n_checked);
		$display("Mismatches: %0d", n_mismatch);
		if (n_mismatch == 0 && rgb_expected.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
